>>> design/ntc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, register indexes, the divider cell payload and the fixed
// segment table of the thermistor linearization.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int ADC_W   = 12;
    localparam int SER_W   = 16;
    localparam int RES_W   = 28;
    localparam int TC_W    = 7;
    localparam int TF_W    = 8;
    localparam int DIFF_W  = 17;
    localparam int SLOPE_W = 14;
    localparam int NSEG    = 9;
    localparam int QMAX    = 10;
    localparam int Q_W     = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 2'd1;

    localparam logic [ADC_W-1:0] SUPPLY_RESET = 12'd3300;
    localparam logic [SER_W-1:0] SERIES_RESET = 16'd10000;

    // Payload handed from one divider cell to the next. The numerator bits
    // leave at the top of nq while quotient bits enter at the bottom.
    typedef struct packed {
        logic [ADC_W-1:0] dvs;
        logic [ADC_W-1:0] rem;
        logic [RES_W-1:0] nq;
    } ntc_div_t;

    localparam logic [RES_W-1:0] SEG_UPPER [NSEG] = '{
        28'd29370, 28'd18680, 28'd12240, 28'd8221, 28'd5648,
        28'd47730, 28'd80360, 28'd140000, 28'd249600
    };

    localparam logic [RES_W-1:0] SEG_LOWER [NSEG] = '{
        28'd18680, 28'd12240, 28'd8221, 28'd5648, 28'd3958,
        28'd29370, 28'd47730, 28'd80360, 28'd140000
    };

    localparam logic [SLOPE_W-1:0] SEG_SLOPE [NSEG] = '{
        14'd1069, 14'd644, 14'd402, 14'd257, 14'd169,
        14'd1836, 14'd3263, 14'd5964, 14'd10960
    };

    localparam logic signed [TC_W-1:0] SEG_BASE [NSEG] = '{
        7'sd0, 7'sd10, 7'sd20, 7'sd30, 7'sd40,
        -7'sd10, -7'sd20, -7'sd30, -7'sd40
    };

    // Only the coldest segment excludes its upper bound.
    localparam logic [NSEG-1:0] SEG_OPEN = 9'b1_0000_0000;

endpackage
`default_nettype wire

>>> design/thermistor_adc_to_temperature.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// NTC divider sample to resistance, Celsius and Fahrenheit.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready with adc_mv in millivolts. Each item
//   yields one result on out_valid/out_ready: res_ohms, temp_c, temp_f and
//   in_range. A sample at or above the supply gives all zeros; a resistance
//   outside the table gives zero temperatures with res_ohms kept.
//   Registers supply_mv (index 0) and series_ohms (index 1) are written on
//   cfg_valid with cfg_index and cfg_data; cfg_ready is always high. Other
//   indexes are ignored. Write them only while no item is in flight.
//   The accepting edge loads the product and divisor into the input
//   register; the item then passes through the chain of divider cells
//   (one quotient bit per cell) and the registered stages for segment
//   search, slope division and Fahrenheit conversion. One item is
//   accepted per cycle while in_ready is high.
//   When the receiver stalls, items pack into empty stages; in_ready drops
//   only once every stage up to the output register holds an item.
//   Reset empties the pipeline and loads supply_mv = 3300, series = 10000.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature
    import ntc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [ADC_W-1:0]      adc_mv,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [RES_W-1:0]           res_ohms,
    output logic signed [TC_W-1:0]     temp_c,
    output logic signed [TF_W-1:0]     temp_f,
    output logic                       in_range
);

    logic [ADC_W-1:0] supply_reg;
    logic [SER_W-1:0] series_reg;

    logic             s0_valid_reg;
    ntc_div_t         s0_data_reg;
    ntc_div_t         s0_data_next;
    logic             s0_ready;
    logic             sample_ok;

    logic             chain_valid [RES_W+1];
    logic             chain_ready [RES_W+1];
    ntc_div_t         chain_data  [RES_W+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= SUPPLY_RESET;
            series_reg <= SERIES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SUPPLY:
                begin
                    supply_reg <= cfg_data[ADC_W-1:0];
                end
                CFG_SERIES:
                begin
                    series_reg <= cfg_data[SER_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // An invalid sample divides zero by one, which yields a zero resistance
    // that lies outside every segment.
    always_comb
    begin
        sample_ok         = (adc_mv < supply_reg);
        s0_data_next.rem  = '0;
        s0_data_next.dvs  = sample_ok ? ADC_W'(supply_reg - adc_mv) : ADC_W'(1);
        s0_data_next.nq   = sample_ok ? RES_W'(RES_W'(adc_mv) * RES_W'(series_reg)) : '0;
    end

    assign s0_ready = !s0_valid_reg || chain_ready[0];
    assign in_ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_ready)
        begin
            s0_data_reg <= s0_data_next;
        end
    end

    assign chain_valid[0] = s0_valid_reg;
    assign chain_data[0]  = s0_data_reg;

    for (genvar i = 0; i < RES_W; i++)
    begin : g_cell
        ntc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    ntc_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[RES_W]),
        .in_ready  (chain_ready[RES_W]),
        .in_res    (chain_data[RES_W].nq),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_ohms  (res_ohms),
        .temp_c    (temp_c),
        .temp_f    (temp_f),
        .in_range  (in_range)
    );

    // Input backpressure only appears once the output holds an item.
    a_ready_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while output register empty");

    a_range_zero_temps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_range) |-> (temp_c == 7'sd0 && temp_f == 8'sd0))
        else $error("out-of-range item carries nonzero temperature");

    a_range_res_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_range) |-> (res_ohms > 28'd3958 && res_ohms < 28'd249600))
        else $error("in-range item with resistance outside the table");

    a_range_temp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_range) |-> (temp_c >= -7'sd40 && temp_c <= 7'sd49))
        else $error("in-range item with temperature outside the table");

endmodule
`default_nettype wire

>>> design/ntc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_div_cell
// One restoring division step: shifts in one numerator bit, produces one
// quotient bit and hands the item to the next cell.
// ----------------------------------------------------------------------------
module ntc_div_cell
    import ntc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ntc_div_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ntc_div_t      out_data
);

    logic              valid_reg;
    ntc_div_t          data_reg;
    ntc_div_t          data_next;
    logic [ADC_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial = {in_data.rem, in_data.nq[RES_W-1]};
        fits  = (trial >= {1'b0, in_data.dvs});
        data_next.dvs = in_data.dvs;
        data_next.rem = fits ? ADC_W'(trial - {1'b0, in_data.dvs}) : trial[ADC_W-1:0];
        data_next.nq  = {in_data.nq[RES_W-2:0], fits};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

>>> design/ntc_seg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_seg
// Segment search, slope division and Celsius to Fahrenheit conversion in
// three registered stages.
// ----------------------------------------------------------------------------
module ntc_seg
    import ntc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [RES_W-1:0] in_res,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [RES_W-1:0]      res_ohms,
    output logic signed [TC_W-1:0] temp_c,
    output logic signed [TF_W-1:0] temp_f,
    output logic                  in_range
);

    // Stage A: segment search and distance below the segment's upper bound.
    logic                     a_valid_reg;
    logic [RES_W-1:0]         a_res_reg;
    logic                     a_hit_reg;
    logic [DIFF_W-1:0]        a_diff_reg;
    logic [SLOPE_W-1:0]       a_slope_reg;
    logic signed [TC_W-1:0]   a_base_reg;
    logic                     a_ready;

    logic [NSEG-1:0]          a_hit_vec;
    logic [RES_W-1:0]         a_upper_sel;
    logic [SLOPE_W-1:0]       a_slope_next;
    logic signed [TC_W-1:0]   a_base_next;
    logic [DIFF_W-1:0]        a_diff_next;

    // Stage B: quotient of the slope division and Celsius temperature.
    logic                     b_valid_reg;
    logic [RES_W-1:0]         b_res_reg;
    logic                     b_hit_reg;
    logic signed [TC_W-1:0]   b_tc_reg;
    logic                     b_ready;
    logic [Q_W-1:0]           b_q;
    logic signed [TC_W-1:0]   b_tc_next;

    // Stage C: Fahrenheit conversion into the output register.
    logic                     c_valid_reg;
    logic [RES_W-1:0]         c_res_reg;
    logic                     c_hit_reg;
    logic signed [TC_W-1:0]   c_tc_reg;
    logic signed [TF_W-1:0]   c_tf_reg;
    logic                     c_ready;
    logic signed [10:0]       c_t18;
    logic [9:0]               c_mag;
    logic [17:0]              c_prod;
    logic [6:0]               c_quo;
    logic signed [TF_W-1:0]   c_tf_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        a_upper_sel  = '0;
        a_slope_next = '0;
        a_base_next  = '0;
        for (int i = 0; i < NSEG; i++)
        begin
            a_hit_vec[i] = (SEG_OPEN[i] ? (in_res < SEG_UPPER[i]) : (in_res <= SEG_UPPER[i]))
                           && (in_res > SEG_LOWER[i]);
            if (a_hit_vec[i])
            begin
                a_upper_sel  = a_upper_sel | SEG_UPPER[i];
                a_slope_next = a_slope_next | SEG_SLOPE[i];
                a_base_next  = a_base_next | SEG_BASE[i];
            end
        end
        a_diff_next = DIFF_W'(a_upper_sel - in_res);
    end

    // Every segment spans at most ten slope steps, so the quotient is a count
    // of constant multiples of the slope that fit in the distance.
    always_comb
    begin
        b_q = '0;
        for (int k = 1; k <= QMAX; k++)
        begin
            if (32'(a_diff_reg) >= 32'(a_slope_reg) * 32'(k))
            begin
                b_q = b_q + Q_W'(1);
            end
        end
        b_tc_next = a_hit_reg ? a_base_reg + $signed({3'b000, b_q}) : '0;
    end

    // Division by ten via multiplication by 205/2048, exact for magnitudes
    // below 1024; the sign is applied afterward to truncate toward zero.
    always_comb
    begin
        c_t18  = 11'(b_tc_reg) * 11'sd18;
        c_mag  = c_t18[10] ? 10'(-c_t18) : 10'(c_t18);
        c_prod = 18'(c_mag) * 18'd205;
        c_quo  = c_prod[17:11];
        if (!b_hit_reg)
        begin
            c_tf_next = '0;
        end
        else if (c_t18[10])
        begin
            c_tf_next = 8'sd32 - $signed({1'b0, c_quo});
        end
        else
        begin
            c_tf_next = 8'sd32 + $signed({1'b0, c_quo});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_res_reg   <= in_res;
            a_hit_reg   <= |a_hit_vec;
            a_diff_reg  <= a_diff_next;
            a_slope_reg <= a_slope_next;
            a_base_reg  <= a_base_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_res_reg <= a_res_reg;
            b_hit_reg <= a_hit_reg;
            b_tc_reg  <= b_tc_next;
        end
        if (b_valid_reg && c_ready)
        begin
            c_res_reg <= b_res_reg;
            c_hit_reg <= b_hit_reg;
            c_tc_reg  <= b_tc_reg;
            c_tf_reg  <= c_tf_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign res_ohms  = c_res_reg;
    assign temp_c    = c_tc_reg;
    assign temp_f    = c_tf_reg;
    assign in_range  = c_hit_reg;

endmodule
`default_nettype wire
